>>> rtl/core/cox_pkg.sv
// Shared types, constants and the control store of the tape-machine code emitter.
// Depends on nothing; the emitter top level imports it.
package cox_pkg;

  localparam int CFG_AW = 5;
  localparam int PC_W   = 8;

  localparam logic [1:0] REG_HOST_WIN = 2'd0;
  localparam logic [1:0] REG_RD_ADDR  = 2'd1;
  localparam logic [1:0] REG_WR_ADDR  = 2'd2;
  localparam logic [1:0] REG_EOI_MODE = 2'd3;

  localparam logic [4:0] MODE_ENTRY    = 5'd0;
  localparam logic [4:0] MODE_EXIT     = 5'd1;
  localparam logic [4:0] MODE_NOP      = 5'd2;
  localparam logic [4:0] MODE_ADD      = 5'd3;
  localparam logic [4:0] MODE_SUB      = 5'd4;
  localparam logic [4:0] MODE_MULADD   = 5'd5;
  localparam logic [4:0] MODE_MULSUB   = 5'd6;
  localparam logic [4:0] MODE_SET      = 5'd7;
  localparam logic [4:0] MODE_PTR_UP   = 5'd8;
  localparam logic [4:0] MODE_PTR_DN   = 5'd9;
  localparam logic [4:0] MODE_READ     = 5'd10;
  localparam logic [4:0] MODE_WRITE    = 5'd11;
  localparam logic [4:0] MODE_JZ       = 5'd12;
  localparam logic [4:0] MODE_JNZ      = 5'd13;
  localparam logic [4:0] MODE_LABEL    = 5'd14;
  localparam logic [4:0] MODE_SCAN_UP  = 5'd15;
  localparam logic [4:0] MODE_SCAN_DN  = 5'd16;

  // Entry points of the microcode routines.
  localparam logic [PC_W-1:0] A_ENTRY  = 8'd0;
  localparam logic [PC_W-1:0] A_EXIT   = 8'd27;
  localparam logic [PC_W-1:0] A_NOP    = 8'd52;
  localparam logic [PC_W-1:0] A_CIMM   = 8'd56;
  localparam logic [PC_W-1:0] A_CIMM_I = 8'd62;
  localparam logic [PC_W-1:0] A_MULL   = 8'd63;
  localparam logic [PC_W-1:0] A_MUL1   = 8'd81;
  localparam logic [PC_W-1:0] A_MULT   = 8'd83;
  localparam logic [PC_W-1:0] A_MULN   = 8'd89;
  localparam logic [PC_W-1:0] A_PTR    = 8'd90;
  localparam logic [PC_W-1:0] A_READ   = 8'd97;
  localparam logic [PC_W-1:0] A_RDCALL = 8'd104;
  localparam logic [PC_W-1:0] A_WRITE  = 8'd133;
  localparam logic [PC_W-1:0] A_WRCALL = 8'd140;
  localparam logic [PC_W-1:0] A_JCC    = 8'd164;
  localparam logic [PC_W-1:0] A_SCAN   = 8'd173;
  localparam logic [PC_W-1:0] A_LAST   = 8'd186;

  typedef enum logic [3:0] {
    S_CONST, S_WIN, S_SHORT, S_MODRM, S_OPC, S_OP2,
    S_AMT, S_DISP, S_STRIDE, S_RADDR, S_WADDR, S_EOI
  } cox_src_e;

  typedef enum logic [1:0] {F_SEQ, F_JUMP, F_STOP} cox_flow_e;
  typedef enum logic [1:0] {C_TRUE, C_DZERO, C_DSHORT} cox_cond_e;
  typedef enum logic [1:0] {K_DROP, K_RUN, K_MARK, K_FAULT} cox_kind_e;

  typedef struct packed {
    cox_src_e          src;
    logic [2:0]        sel;
    logic [7:0]        k;
    logic [7:0]        alt;
    cox_flow_e         flow;
    cox_cond_e         cond;
    logic [PC_W-1:0]   tgt;
  } cox_cw_t;

  typedef struct packed {
    cox_kind_e         kind;
    logic [PC_W-1:0]   pc;
    logic [7:0]        opc;
    logic [7:0]        op2;
  } cox_disp_t;

  function automatic cox_cw_t cw(cox_src_e s, logic [2:0] sel, logic [7:0] k,
                                 logic [7:0] alt, cox_flow_e f, cox_cond_e c,
                                 logic [PC_W-1:0] t);
    cox_cw_t w;
    w.src  = s;
    w.sel  = sel;
    w.k    = k;
    w.alt  = alt;
    w.flow = f;
    w.cond = c;
    w.tgt  = t;
    return w;
  endfunction

  function automatic cox_cw_t kb(logic [7:0] k);
    return cw(S_CONST, 3'd0, k, 8'h00, F_SEQ, C_TRUE, '0);
  endfunction

  function automatic cox_cw_t ks(logic [7:0] k);
    return cw(S_CONST, 3'd0, k, 8'h00, F_STOP, C_TRUE, '0);
  endfunction

  function automatic cox_cw_t sb(cox_src_e s, logic [2:0] sel);
    return cw(s, sel, 8'h00, 8'h00, F_SEQ, C_TRUE, '0);
  endfunction

  function automatic cox_cw_t cox_rom(logic [PC_W-1:0] a);
    cox_cw_t w;
    unique case (a)
      8'd0: w = kb(8'h41);   8'd1: w = kb(8'h57);
      8'd2: w = kb(8'h41);   8'd3: w = kb(8'h56);
      8'd4: w = kb(8'h41);   8'd5: w = kb(8'h55);
      8'd6: w = kb(8'h41);   8'd7: w = kb(8'h54);
      8'd8: w = kb(8'h41);   8'd9: w = kb(8'h53);
      8'd10: w = kb(8'h41);  8'd11: w = kb(8'h52);
      8'd12: w = kb(8'h41);  8'd13: w = kb(8'h51);
      8'd14: w = kb(8'h41);  8'd15: w = kb(8'h50);
      8'd16: w = kb(8'h57);  8'd17: w = kb(8'h56);
      8'd18: w = kb(8'h55);  8'd19: w = kb(8'h54);
      8'd20: w = kb(8'h53);  8'd21: w = kb(8'h52);
      8'd22: w = kb(8'h51);  8'd23: w = kb(8'h50);
      8'd24: w = kb(8'h48);  8'd25: w = kb(8'h89);
      8'd26: w = cw(S_WIN, 3'd0, 8'hFA, 8'hCA, F_STOP, C_TRUE, '0);
      8'd27: w = kb(8'h58);  8'd28: w = kb(8'h59);
      8'd29: w = kb(8'h5A);  8'd30: w = kb(8'h5B);
      8'd31: w = kb(8'h5C);  8'd32: w = kb(8'h5D);
      8'd33: w = kb(8'h5E);  8'd34: w = kb(8'h5F);
      8'd35: w = kb(8'h41);  8'd36: w = kb(8'h58);
      8'd37: w = kb(8'h41);  8'd38: w = kb(8'h59);
      8'd39: w = kb(8'h41);  8'd40: w = kb(8'h5A);
      8'd41: w = kb(8'h41);  8'd42: w = kb(8'h5B);
      8'd43: w = kb(8'h41);  8'd44: w = kb(8'h5C);
      8'd45: w = kb(8'h41);  8'd46: w = kb(8'h5D);
      8'd47: w = kb(8'h41);  8'd48: w = kb(8'h5E);
      8'd49: w = kb(8'h41);  8'd50: w = kb(8'h5F);
      8'd51: w = ks(8'hC3);
      8'd52: w = kb(8'h90);  8'd53: w = kb(8'h90);
      8'd54: w = kb(8'h90);  8'd55: w = ks(8'h90);
      8'd56: w = sb(S_OPC, 3'd0);
      8'd57: w = cw(S_MODRM, 3'd0, 8'h00, 8'h00, F_JUMP, C_DZERO, A_CIMM_I);
      8'd58: w = cw(S_DISP, 3'd0, 8'h00, 8'h00, F_JUMP, C_DSHORT, A_CIMM_I);
      8'd59: w = sb(S_DISP, 3'd1);
      8'd60: w = sb(S_DISP, 3'd2);
      8'd61: w = sb(S_DISP, 3'd3);
      8'd62: w = cw(S_AMT, 3'd0, 8'h00, 8'h00, F_STOP, C_TRUE, '0);
      8'd63: w = kb(8'h49);  8'd64: w = kb(8'h89);
      8'd65: w = kb(8'hD0);  8'd66: w = kb(8'h48);
      8'd67: w = kb(8'hC7);  8'd68: w = kb(8'hC0);
      8'd69: w = sb(S_AMT, 3'd0);
      8'd70: w = kb(8'h00);  8'd71: w = kb(8'h00);
      8'd72: w = kb(8'h00);  8'd73: w = kb(8'h8A);
      8'd74: w = kb(8'h1A);  8'd75: w = kb(8'h48);
      8'd76: w = kb(8'hF7);  8'd77: w = kb(8'hE3);
      8'd78: w = kb(8'h4C);  8'd79: w = kb(8'h89);
      8'd80: w = cw(S_CONST, 3'd0, 8'hC2, 8'h00, F_JUMP, C_TRUE, A_MULT);
      8'd81: w = kb(8'h8A);  8'd82: w = kb(8'h02);
      8'd83: w = sb(S_OPC, 3'd0);
      8'd84: w = cw(S_SHORT, 3'd0, 8'h42, 8'h82, F_SEQ, C_TRUE, '0);
      8'd85: w = cw(S_DISP, 3'd0, 8'h00, 8'h00, F_STOP, C_DSHORT, '0);
      8'd86: w = sb(S_DISP, 3'd1);
      8'd87: w = sb(S_DISP, 3'd2);
      8'd88: w = cw(S_DISP, 3'd3, 8'h00, 8'h00, F_STOP, C_TRUE, '0);
      8'd89: w = ks(8'h90);
      8'd90: w = kb(8'h48);
      8'd91: w = cw(S_SHORT, 3'd0, 8'h83, 8'h81, F_SEQ, C_TRUE, '0);
      8'd92: w = sb(S_OP2, 3'd0);
      8'd93: w = cw(S_DISP, 3'd0, 8'h00, 8'h00, F_STOP, C_DSHORT, '0);
      8'd94: w = sb(S_DISP, 3'd1);
      8'd95: w = sb(S_DISP, 3'd2);
      8'd96: w = cw(S_DISP, 3'd3, 8'h00, 8'h00, F_STOP, C_TRUE, '0);
      8'd97: w = kb(8'h48);
      8'd98: w = cw(S_SHORT, 3'd0, 8'h83, 8'h81, F_SEQ, C_TRUE, '0);
      8'd99: w = kb(8'hC2);
      8'd100: w = cw(S_DISP, 3'd0, 8'h00, 8'h00, F_JUMP, C_DSHORT, A_RDCALL);
      8'd101: w = sb(S_DISP, 3'd1);
      8'd102: w = sb(S_DISP, 3'd2);
      8'd103: w = sb(S_DISP, 3'd3);
      8'd104: w = kb(8'h52);  8'd105: w = kb(8'h48);
      8'd106: w = kb(8'hB8);
      8'd107: w = sb(S_RADDR, 3'd0);  8'd108: w = sb(S_RADDR, 3'd1);
      8'd109: w = sb(S_RADDR, 3'd2);  8'd110: w = sb(S_RADDR, 3'd3);
      8'd111: w = sb(S_RADDR, 3'd4);  8'd112: w = sb(S_RADDR, 3'd5);
      8'd113: w = sb(S_RADDR, 3'd6);  8'd114: w = sb(S_RADDR, 3'd7);
      8'd115: w = kb(8'h48);  8'd116: w = kb(8'h89);
      8'd117: w = cw(S_WIN, 3'd0, 8'hD7, 8'hD1, F_SEQ, C_TRUE, '0);
      8'd118: w = cw(S_WIN, 3'd0, 8'hBE, 8'hBA, F_SEQ, C_TRUE, '0);
      8'd119: w = sb(S_EOI, 3'd0);  8'd120: w = sb(S_EOI, 3'd1);
      8'd121: w = sb(S_EOI, 3'd2);  8'd122: w = sb(S_EOI, 3'd3);
      8'd123: w = kb(8'hFF);  8'd124: w = kb(8'hD0);
      8'd125: w = kb(8'h5A);  8'd126: w = kb(8'h48);
      8'd127: w = cw(S_SHORT, 3'd0, 8'h83, 8'h81, F_SEQ, C_TRUE, '0);
      8'd128: w = kb(8'hEA);
      8'd129: w = cw(S_DISP, 3'd0, 8'h00, 8'h00, F_STOP, C_DSHORT, '0);
      8'd130: w = sb(S_DISP, 3'd1);
      8'd131: w = sb(S_DISP, 3'd2);
      8'd132: w = cw(S_DISP, 3'd3, 8'h00, 8'h00, F_STOP, C_TRUE, '0);
      8'd133: w = kb(8'h48);
      8'd134: w = cw(S_SHORT, 3'd0, 8'h83, 8'h81, F_SEQ, C_TRUE, '0);
      8'd135: w = kb(8'hC2);
      8'd136: w = cw(S_DISP, 3'd0, 8'h00, 8'h00, F_JUMP, C_DSHORT, A_WRCALL);
      8'd137: w = sb(S_DISP, 3'd1);
      8'd138: w = sb(S_DISP, 3'd2);
      8'd139: w = sb(S_DISP, 3'd3);
      8'd140: w = kb(8'h52);  8'd141: w = kb(8'h48);
      8'd142: w = kb(8'hB8);
      8'd143: w = sb(S_WADDR, 3'd0);  8'd144: w = sb(S_WADDR, 3'd1);
      8'd145: w = sb(S_WADDR, 3'd2);  8'd146: w = sb(S_WADDR, 3'd3);
      8'd147: w = sb(S_WADDR, 3'd4);  8'd148: w = sb(S_WADDR, 3'd5);
      8'd149: w = sb(S_WADDR, 3'd6);  8'd150: w = sb(S_WADDR, 3'd7);
      8'd151: w = kb(8'h48);  8'd152: w = kb(8'h89);
      8'd153: w = cw(S_WIN, 3'd0, 8'hD7, 8'hD1, F_SEQ, C_TRUE, '0);
      8'd154: w = kb(8'hFF);  8'd155: w = kb(8'hD0);
      8'd156: w = kb(8'h5A);  8'd157: w = kb(8'h48);
      8'd158: w = cw(S_SHORT, 3'd0, 8'h83, 8'h81, F_SEQ, C_TRUE, '0);
      8'd159: w = kb(8'hEA);
      8'd160: w = cw(S_DISP, 3'd0, 8'h00, 8'h00, F_STOP, C_DSHORT, '0);
      8'd161: w = sb(S_DISP, 3'd1);
      8'd162: w = sb(S_DISP, 3'd2);
      8'd163: w = cw(S_DISP, 3'd3, 8'h00, 8'h00, F_STOP, C_TRUE, '0);
      8'd164: w = kb(8'h80);  8'd165: w = kb(8'h3A);
      8'd166: w = kb(8'h00);  8'd167: w = kb(8'h0F);
      8'd168: w = sb(S_OP2, 3'd0);
      8'd169: w = kb(8'h00);  8'd170: w = kb(8'h00);
      8'd171: w = kb(8'h00);  8'd172: w = ks(8'h00);
      8'd173: w = kb(8'h80);  8'd174: w = kb(8'h3A);
      8'd175: w = sb(S_AMT, 3'd0);
      8'd176: w = kb(8'h74);  8'd177: w = kb(8'h09);
      8'd178: w = kb(8'h48);  8'd179: w = kb(8'h81);
      8'd180: w = sb(S_OP2, 3'd0);
      8'd181: w = sb(S_STRIDE, 3'd0);  8'd182: w = sb(S_STRIDE, 3'd1);
      8'd183: w = sb(S_STRIDE, 3'd2);  8'd184: w = sb(S_STRIDE, 3'd3);
      8'd185: w = kb(8'hEB);
      8'd186: w = ks(8'hF2);
      default: w = ks(8'h00);
    endcase
    return w;
  endfunction

  function automatic cox_disp_t cox_dispatch(logic [4:0] mode, logic amt_one,
                                             logic dzero, logic stride_ones);
    cox_disp_t r;
    r.kind = K_RUN;
    r.pc   = A_NOP;
    r.opc  = 8'h00;
    r.op2  = 8'h00;
    unique case (mode)
      MODE_ENTRY: r.pc = A_ENTRY;
      MODE_EXIT:  r.pc = A_EXIT;
      MODE_NOP:   r.pc = A_NOP;
      MODE_ADD: begin
        r.pc = A_CIMM; r.opc = 8'h80; r.op2 = 8'h02;
      end
      MODE_SUB: begin
        r.pc = A_CIMM; r.opc = 8'h80; r.op2 = 8'h2A;
      end
      MODE_SET: begin
        r.pc = A_CIMM; r.opc = 8'hC6; r.op2 = 8'h02;
      end
      MODE_MULADD, MODE_MULSUB: begin
        r.opc = (mode == MODE_MULADD) ? 8'h00 : 8'h28;
        r.pc  = dzero ? A_MULN : (amt_one ? A_MUL1 : A_MULL);
      end
      MODE_PTR_UP: begin
        r.pc = A_PTR; r.op2 = 8'hC2;
      end
      MODE_PTR_DN: begin
        r.pc = A_PTR; r.op2 = 8'hEA;
      end
      MODE_READ:  r.pc = A_READ;
      MODE_WRITE: r.pc = A_WRITE;
      MODE_JZ: begin
        r.pc = A_JCC; r.op2 = 8'h84;
      end
      MODE_JNZ: begin
        r.pc = A_JCC; r.op2 = 8'h85;
      end
      MODE_LABEL: r.kind = K_MARK;
      MODE_SCAN_UP, MODE_SCAN_DN: begin
        r.pc   = A_SCAN;
        r.op2  = (mode == MODE_SCAN_UP) ? 8'hC2 : 8'hEA;
        r.kind = stride_ones ? K_FAULT : K_RUN;
      end
      default: r.kind = K_DROP;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/cox_op_if.sv
// Operation channel: one tape-machine operation per transaction.
// Stands alone; used by the emitter top level.
interface cox_op_if;
  logic               valid;
  logic               ready;
  logic        [4:0]  mode;
  logic        [7:0]  amount;
  logic signed [31:0] displacement;
  logic        [31:0] stride;

  modport source (output valid, mode, amount, displacement, stride, input ready);
  modport sink (input valid, mode, amount, displacement, stride, output ready);
endinterface

>>> rtl/core/cox_res_if.sv
// Result channel: one emitted code byte or byteless marker per transaction.
// Stands alone; used by the emitter top level.
interface cox_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  code_byte;
  logic        has_byte;
  logic [31:0] byte_address;
  logic        error;
  logic        last;

  modport source (output valid, code_byte, has_byte, byte_address, error, last,
                  input ready);
  modport sink (input valid, code_byte, has_byte, byte_address, error, last,
                output ready);
endinterface

>>> rtl/core/cell_op_x86_code_emitter.sv
// Top level of the tape-machine operation to x86-64 code emitter.
// Depends on cox_pkg (control store, dispatch) and the cox_op_if / cox_res_if channels.
//
// Channel   Direction  Transaction
// op_i      in         one operation (mode, amount, displacement, stride)
// res_o     out        one code byte with address, or a byteless marker
// APB       in/out     host flag, helper addresses, end-of-input code
//
// A sequencer steps through the control store and emits one byte per cycle while the
// result is not stalled; the longest operation is a read with long pointer moves.
// Labels and bad scan strides give a byteless marker and do not start the sequencer.
// Reset clears the byte counter, the registers and the control state.
// A stalled result holds the sequencer; no new operation enters while it runs.
module cell_op_x86_code_emitter (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  cox_op_if.sink                     op_i,
  cox_res_if.source                  res_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cox_pkg::CFG_AW-1:0] paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready
);
  import cox_pkg::*;

  logic                host_win_q;
  logic [63:0]         rd_addr_q;
  logic [63:0]         wr_addr_q;
  logic [31:0]         eoi_mode_q;
  logic [31:0]         cnt_q;

  logic                busy_q;
  logic [PC_W-1:0]     pc_q;
  logic [7:0]          amt_q;
  logic [31:0]         disp_q;
  logic [31:0]         stride_q;
  logic [7:0]          opc_q;
  logic [7:0]          op2_q;
  logic                dzero_q;
  logic                dshort_q;

  logic                res_valid_q;
  logic [7:0]          res_byte_q;
  logic                res_has_q;
  logic [31:0]         res_addr_q;
  logic                res_err_q;
  logic                res_last_q;

  logic                cfg_wr;
  logic                out_free;
  logic                accept;
  logic                step;
  logic                taken;
  logic                stop;
  logic                jump;
  logic [7:0]          byte_val;
  logic [31:0]         disp_in;
  logic                dshort_in;
  cox_cw_t             cw_cur;
  cox_disp_t           disp_info;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[4:3])
      REG_HOST_WIN: prdata = {63'd0, host_win_q};
      REG_RD_ADDR:  prdata = rd_addr_q;
      REG_WR_ADDR:  prdata = wr_addr_q;
      REG_EOI_MODE: prdata = {32'd0, eoi_mode_q};
      default:      prdata = 64'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      host_win_q <= 1'b0;
      rd_addr_q  <= 64'd0;
      wr_addr_q  <= 64'd0;
      eoi_mode_q <= 32'd0;
    end else if (cfg_wr) begin
      unique case (paddr[4:3])
        REG_HOST_WIN: host_win_q <= pwdata[0];
        REG_RD_ADDR:  rd_addr_q  <= pwdata;
        REG_WR_ADDR:  wr_addr_q  <= pwdata;
        REG_EOI_MODE: eoi_mode_q <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  assign out_free   = !res_valid_q || res_o.ready;
  assign op_i.ready = !busy_q && out_free;
  assign accept     = op_i.valid && op_i.ready;
  assign step       = busy_q && out_free;

  assign disp_in   = op_i.displacement;
  assign dshort_in = (disp_in <= 32'd127) || (disp_in >= 32'hFFFF_FF81);
  assign disp_info = cox_dispatch(op_i.mode, op_i.amount == 8'd1, disp_in == 32'd0,
                                  op_i.stride == 32'hFFFF_FFFF);

  assign cw_cur = cox_rom(pc_q);

  always_comb begin
    unique case (cw_cur.cond)
      C_TRUE:   taken = 1'b1;
      C_DZERO:  taken = dzero_q;
      C_DSHORT: taken = dshort_q;
      default:  taken = 1'b0;
    endcase
  end

  assign stop = (cw_cur.flow == F_STOP) && taken;
  assign jump = (cw_cur.flow == F_JUMP) && taken;

  always_comb begin
    unique case (cw_cur.src)
      S_CONST:  byte_val = cw_cur.k;
      S_WIN:    byte_val = host_win_q ? cw_cur.alt : cw_cur.k;
      S_SHORT:  byte_val = dshort_q ? cw_cur.k : cw_cur.alt;
      S_MODRM:  byte_val = op2_q | (dzero_q ? 8'h00 : (dshort_q ? 8'h40 : 8'h80));
      S_OPC:    byte_val = opc_q;
      S_OP2:    byte_val = op2_q;
      S_AMT:    byte_val = amt_q;
      S_DISP:   byte_val = disp_q[{cw_cur.sel[1:0], 3'b000} +: 8];
      S_STRIDE: byte_val = stride_q[{cw_cur.sel[1:0], 3'b000} +: 8];
      S_RADDR:  byte_val = rd_addr_q[{cw_cur.sel, 3'b000} +: 8];
      S_WADDR:  byte_val = wr_addr_q[{cw_cur.sel, 3'b000} +: 8];
      S_EOI:    byte_val = eoi_mode_q[{cw_cur.sel[1:0], 3'b000} +: 8];
      default:  byte_val = 8'h00;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= '0;
    end else if (accept) begin
      busy_q <= (disp_info.kind == K_RUN);
      pc_q   <= disp_info.pc;
    end else if (step) begin
      busy_q <= !stop;
      pc_q   <= jump ? cw_cur.tgt : pc_q + PC_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      amt_q    <= op_i.amount;
      disp_q   <= disp_in;
      stride_q <= op_i.stride;
      opc_q    <= disp_info.opc;
      op2_q    <= disp_info.op2;
      dzero_q  <= (disp_in == 32'd0);
      dshort_q <= dshort_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 32'd0;
    end else if (step) begin
      cnt_q <= cnt_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (step || (accept && (disp_info.kind == K_MARK ||
                                     disp_info.kind == K_FAULT))) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_byte_q <= byte_val;
      res_has_q  <= 1'b1;
      res_addr_q <= cnt_q;
      res_err_q  <= 1'b0;
      res_last_q <= stop;
    end else if (accept) begin
      res_byte_q <= 8'h00;
      res_has_q  <= 1'b0;
      res_addr_q <= cnt_q;
      res_err_q  <= (disp_info.kind == K_FAULT);
      res_last_q <= 1'b1;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.code_byte    = res_byte_q;
  assign res_o.has_byte     = res_has_q;
  assign res_o.byte_address = res_addr_q;
  assign res_o.error        = res_err_q;
  assign res_o.last         = res_last_q;

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> cnt_q == $past(cnt_q) + 32'd1)
    else $error("byte counter did not advance with an emitted byte");

  a_stop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && stop) |=> !busy_q)
    else $error("sequencer still busy after its final step");

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> pc_q <= A_LAST)
    else $error("sequencer left the control store");

  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_has_q) |-> res_last_q)
    else $error("byteless result without last mark");

  a_err_byteless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_err_q) |-> !res_has_q)
    else $error("error flag set on a code byte");

endmodule
